@@ hw/rtl/wsfu_pkg.sv @@
// ----------------------------------------------------------------------------
// wsfu_pkg
// Types and codes shared by the WebSocket frame unmasker modules.
// ----------------------------------------------------------------------------
package wsfu_pkg;

    localparam int ByteW   = 8;
    localparam int LenW    = 16;
    localparam int KeyW    = 32;

    localparam logic [6:0] LEN_CODE_MASK = 7'h7F;
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [2:0] KEY_LAST_IDX  = 3'd3;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT_HI  = 3'd2,
        PH_EXT_LO  = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_SKIP    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_TRUNCATED   = 2'd1,
        ERR_UNSUPPORTED = 2'd2
    } err_code_t;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             has_data;
        logic             frame_done;
        err_code_t        error_code;
        logic [LenW-1:0]  payload_length;
    } result_t;

endpackage

@@ hw/rtl/wsfu_parser.sv @@
// ----------------------------------------------------------------------------
// wsfu_parser
// Frame header parser, key capture and payload unmask for one byte per step.
// ----------------------------------------------------------------------------
module wsfu_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  logic [wsfu_pkg::ByteW-1:0]   in_byte,
    input  logic                         end_of_buffer,
    output logic                         emit,
    output wsfu_pkg::result_t            result
);

    wsfu_pkg::phase_t                 phase_reg, phase_next;
    logic [wsfu_pkg::LenW-1:0]        len_reg, len_next;
    logic [wsfu_pkg::LenW-1:0]        cnt_reg, cnt_next;
    logic [wsfu_pkg::KeyW-1:0]        key_reg, key_next;

    logic [6:0]                       len_code;
    logic [wsfu_pkg::LenW-1:0]        cnt_inc;
    logic [wsfu_pkg::ByteW-1:0]       key_byte;
    logic                             rearm;

    assign len_code = in_byte[6:0] & wsfu_pkg::LEN_CODE_MASK;
    assign cnt_inc  = cnt_reg + 1'b1;

    // Key byte for this payload index: index 0 takes the first key byte.
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        emit       = 1'b0;
        rearm      = 1'b0;
        result     = '0;

        case (phase_reg)
            wsfu_pkg::PH_FIRST: begin
                if (end_of_buffer) begin
                    emit              = 1'b1;
                    result.frame_done = 1'b1;
                    result.error_code = wsfu_pkg::ERR_TRUNCATED;
                    rearm             = 1'b1;
                end else begin
                    phase_next = wsfu_pkg::PH_LEN;
                end
            end
            wsfu_pkg::PH_LEN: begin
                if (len_code == wsfu_pkg::LEN_CODE_EXT64) begin
                    len_next          = '0;
                    emit              = 1'b1;
                    result.frame_done = 1'b1;
                    result.error_code = wsfu_pkg::ERR_UNSUPPORTED;
                    rearm             = end_of_buffer;
                    phase_next        = wsfu_pkg::PH_SKIP;
                end else begin
                    if (len_code == wsfu_pkg::LEN_CODE_EXT16) begin
                        len_next   = '0;
                        phase_next = wsfu_pkg::PH_EXT_HI;
                    end else begin
                        len_next   = {{(wsfu_pkg::LenW-7){1'b0}}, len_code};
                        cnt_next   = '0;
                        phase_next = wsfu_pkg::PH_KEY;
                    end
                    if (end_of_buffer) begin
                        emit              = 1'b1;
                        result.frame_done = 1'b1;
                        result.error_code = wsfu_pkg::ERR_TRUNCATED;
                        rearm             = 1'b1;
                    end
                end
            end
            wsfu_pkg::PH_EXT_HI: begin
                len_next   = {in_byte, {(wsfu_pkg::LenW-wsfu_pkg::ByteW){1'b0}}};
                phase_next = wsfu_pkg::PH_EXT_LO;
                if (end_of_buffer) begin
                    emit              = 1'b1;
                    result.frame_done = 1'b1;
                    result.error_code = wsfu_pkg::ERR_TRUNCATED;
                    rearm             = 1'b1;
                end
            end
            wsfu_pkg::PH_EXT_LO: begin
                len_next   = len_reg | {{(wsfu_pkg::LenW-wsfu_pkg::ByteW){1'b0}}, in_byte};
                cnt_next   = '0;
                phase_next = wsfu_pkg::PH_KEY;
                if (end_of_buffer) begin
                    emit              = 1'b1;
                    result.frame_done = 1'b1;
                    result.error_code = wsfu_pkg::ERR_TRUNCATED;
                    rearm             = 1'b1;
                end
            end
            wsfu_pkg::PH_KEY: begin
                key_next = {key_reg[wsfu_pkg::KeyW-wsfu_pkg::ByteW-1:0], in_byte};
                cnt_next = cnt_inc;
                if (cnt_reg[2:0] == wsfu_pkg::KEY_LAST_IDX) begin
                    cnt_next = '0;
                    if (len_reg == '0) begin
                        // Empty frame: one bare done beat.
                        emit              = 1'b1;
                        result.frame_done = 1'b1;
                        result.error_code = wsfu_pkg::ERR_NONE;
                        rearm             = end_of_buffer;
                        phase_next        = wsfu_pkg::PH_SKIP;
                    end else begin
                        phase_next = wsfu_pkg::PH_PAYLOAD;
                    end
                end
                if (end_of_buffer && !emit) begin
                    emit              = 1'b1;
                    result.frame_done = 1'b1;
                    result.error_code = wsfu_pkg::ERR_TRUNCATED;
                    rearm             = 1'b1;
                end
            end
            wsfu_pkg::PH_PAYLOAD: begin
                cnt_next        = cnt_inc;
                emit            = 1'b1;
                result.out_byte = in_byte ^ key_byte;
                result.has_data = 1'b1;
                if (cnt_inc == len_reg) begin
                    result.frame_done = 1'b1;
                    result.error_code = wsfu_pkg::ERR_NONE;
                    rearm             = end_of_buffer;
                    phase_next        = wsfu_pkg::PH_SKIP;
                end else if (end_of_buffer) begin
                    result.frame_done = 1'b1;
                    result.error_code = wsfu_pkg::ERR_TRUNCATED;
                    rearm             = 1'b1;
                end
            end
            default: begin
                // Drop trailing bytes until the buffer ends.
                rearm = end_of_buffer;
            end
        endcase

        // Length reported is the one after this byte, before any rearm.
        result.payload_length = len_next;

        if (rearm) begin
            phase_next = wsfu_pkg::PH_FIRST;
            len_next   = '0;
            cnt_next   = '0;
            key_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wsfu_pkg::PH_FIRST;
            len_reg   <= '0;
            cnt_reg   <= '0;
            key_reg   <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            key_reg   <= key_next;
        end
    end

    a_data_only_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && emit && result.has_data) |-> (phase_reg == wsfu_pkg::PH_PAYLOAD))
        else $error("payload beat outside payload phase");

    a_key_index_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == wsfu_pkg::PH_KEY) |-> (cnt_reg < 16'd4))
        else $error("key byte index out of range");

    a_eob_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && end_of_buffer) |=> (phase_reg == wsfu_pkg::PH_FIRST && cnt_reg == '0))
        else $error("end of buffer did not rearm parser");

    a_unsupported_is_bare: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && emit && result.error_code == wsfu_pkg::ERR_UNSUPPORTED)
        |-> (result.frame_done && !result.has_data && result.payload_length == '0))
        else $error("unsupported length beat malformed");

endmodule

@@ hw/rtl/websocket_frame_unmasker.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Unmasks the payload of received client-to-server WebSocket frames.
// ----------------------------------------------------------------------------
// Feed the received buffer one byte per beat, with s_end_of_buffer on the
// last byte. The first byte is ignored, the second gives the 7-bit length
// (126 selects a 16-bit big-endian extended length, 127 is reported as
// unsupported), then four masking key bytes follow. Each payload byte comes
// out XORed with its key byte, the last one flagged with m_frame_done; an
// empty frame gives a single done beat with no data. A buffer that ends
// before the frame completes gives a truncation error and rearms the parser;
// bytes after a finished frame are dropped until end of buffer. The block
// takes one byte per cycle while the result register is empty or being
// taken: a byte is held in the input register, parsed and unmasked in one
// step, and the beat it produces waits in the result register. Both
// registers advance together under that same condition.
module websocket_frame_unmasker (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [wsfu_pkg::ByteW-1:0]   s_in_byte,
    input  logic                         s_end_of_buffer,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [wsfu_pkg::ByteW-1:0]   m_out_byte,
    output logic                         m_has_data,
    output logic                         m_frame_done,
    output logic [1:0]                   m_error_code,
    output logic [wsfu_pkg::LenW-1:0]    m_payload_length
);

    logic                         pipe_en;
    logic                         in_valid_reg;
    logic [wsfu_pkg::ByteW-1:0]   in_byte_reg;
    logic                         in_eob_reg;

    logic                         emit;
    wsfu_pkg::result_t            step_result;

    logic                         out_valid_reg;
    wsfu_pkg::result_t            out_result_reg;

    // Advance the whole pipe unless a finished beat is still waiting.
    assign pipe_en = !out_valid_reg || m_ready;
    assign s_ready = pipe_en;

    // Input register: hold the accepted byte for the parse step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && s_valid) begin
            in_byte_reg <= s_in_byte;
            in_eob_reg  <= s_end_of_buffer;
        end
    end

    wsfu_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (pipe_en && in_valid_reg),
        .in_byte       (in_byte_reg),
        .end_of_buffer (in_eob_reg),
        .emit          (emit),
        .result        (step_result)
    );

    // Result register: capture a beat only when the step produced one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= in_valid_reg && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && in_valid_reg && emit) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_out_byte       = out_result_reg.out_byte;
    assign m_has_data       = out_result_reg.has_data;
    assign m_frame_done     = out_result_reg.frame_done;
    assign m_error_code     = out_result_reg.error_code;
    assign m_payload_length = out_result_reg.payload_length;

endmodule
